// File: rtl/fbld_pkg.sv
// Shared constants, request and state codes, and control structs for the
// frame buffer line drawer. No dependencies.
package fbld_pkg;

  localparam int DISP_WIDTH  = 128;
  localparam int DISP_HEIGHT = 64;
  localparam int PAGE_SHIFT  = 3;
  localparam int FB_PAGES    = DISP_HEIGHT / 8;
  localparam int FB_BYTES    = DISP_WIDTH * FB_PAGES;
  localparam int ADDR_W      = $clog2(FB_BYTES);

  localparam int REQ_W  = 2;
  localparam int X_W    = 7;
  localparam int Y_W    = 6;
  localparam int BI_W   = 10;
  localparam int DATA_W = 8;
  localparam int IDX_W  = 16;
  localparam int ERR_W  = 10;

  typedef enum logic [REQ_W-1:0] {
    REQ_PIXEL = 2'd0,
    REQ_LINE  = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_BYTE_RD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } bres_ctl_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           last;
  } bres_pos_t;

endpackage

// File: rtl/fbld_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on fbld_pkg.
interface fbld_in_if;
  import fbld_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [X_W-1:0]    start_x;
  logic [Y_W-1:0]    start_y;
  logic [X_W-1:0]    end_x;
  logic [Y_W-1:0]    end_y;
  logic              pixel_on;
  logic [BI_W-1:0]   byte_index;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, pixel_on,
                  byte_index, input ready);
  modport sink (input valid, req_type, start_x, start_y, end_x, end_y, pixel_on,
                byte_index, output ready);
endinterface

interface fbld_out_if;
  import fbld_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// File: rtl/fbld_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module fbld_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/fbld_bres.sv
// Bresenham step unit: holds the current point and error term, advances one
// point per step strobe. Depends on fbld_pkg.
module fbld_bres (
  input  logic                    clk,
  input  fbld_pkg::bres_ctl_t     ctl,
  input  logic [fbld_pkg::X_W-1:0] x0,
  input  logic [fbld_pkg::Y_W-1:0] y0,
  input  logic [fbld_pkg::X_W-1:0] x1,
  input  logic [fbld_pkg::Y_W-1:0] y1,
  output fbld_pkg::bres_pos_t     pos
);
  import fbld_pkg::*;

  logic [X_W-1:0]          x_r, x_nxt, x1_r, dx_r, dx_ld;
  logic [Y_W-1:0]          y_r, y_nxt, y1_r, dy_r, dy_ld;
  logic                    sx_r, sy_r;
  logic signed [ERR_W-1:0] err_r, err_nxt, err_ld;
  logic signed [ERR_W:0]   e2, dx_s, dy_s, err_sum;
  logic                    go_x, go_y;

  always_comb begin
    dx_ld  = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    dy_ld  = (y1 > y0) ? (y1 - y0) : (y0 - y1);
    err_ld = $signed(ERR_W'(dx_ld)) - $signed(ERR_W'(dy_ld));

    e2   = $signed({err_r, 1'b0});
    dx_s = $signed((ERR_W + 1)'(dx_r));
    dy_s = $signed((ERR_W + 1)'(dy_r));
    go_x = e2 > -dy_s;
    go_y = e2 < dx_s;

    err_sum = $signed({err_r[ERR_W-1], err_r})
            - (go_x ? dy_s : '0)
            + (go_y ? dx_s : '0);
    err_nxt = err_sum[ERR_W-1:0];
    x_nxt   = go_x ? (sx_r ? x_r + 1'b1 : x_r - 1'b1) : x_r;
    y_nxt   = go_y ? (sy_r ? y_r + 1'b1 : y_r - 1'b1) : y_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r   <= x0;
      y_r   <= y0;
      x1_r  <= x1;
      y1_r  <= y1;
      dx_r  <= dx_ld;
      dy_r  <= dy_ld;
      sx_r  <= x0 < x1;
      sy_r  <= y0 < y1;
      err_r <= err_ld;
    end else if (ctl.step) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
    end
  end

  assign pos.x    = x_r;
  assign pos.y    = y_r;
  assign pos.last = (x_r == x1_r) && (y_r == y1_r);

endmodule

// File: rtl/framebuffer_line_drawer_core.sv
// Frame buffer line drawer: pixel, line, fill and byte read requests on a
// 1 bit per pixel column-major buffer. Depends on fbld_pkg, fbld_if,
// fbld_ram and fbld_bres.
//
// Usage: requests arrive on in_ch, one beat per request; every request
// gives exactly one beat on out_ch (read_data is the byte for a read, zero
// otherwise). in_ch.ready is high only while the sequencer is idle.
// The single RAM port pair sets the pace: each pixel is a read-modify-write
// (read cycle, then write cycle), and a fill writes one byte per cycle.
// Reset: a clearing sweep writes zero to all FB_BYTES (1024) bytes, one per
// cycle; in_ch.ready stays low during the sweep.
// Result beats sit in an output register; a new request is taken while a
// result waits, and the sequencer holds at its final cycle only if the
// output register is still full when the next result is ready.
module framebuffer_line_drawer_core (
  input logic      clk,
  input logic      rst_n,
  fbld_in_if.sink  in_ch,
  fbld_out_if.source out_ch
);
  import fbld_pkg::*;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [DATA_W-1:0]   sweep_data_r, sweep_data_nxt;
  logic                report_r, report_nxt;
  req_t                req_r, req_nxt;
  logic                on_r, on_nxt;
  logic [DATA_W-1:0]   result_r, result_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;

  logic                in_ready, in_fire, out_push;
  req_t                in_req;
  bres_ctl_t           bctl;
  bres_pos_t           pos;
  logic [X_W-1:0]      ld_x1;
  logic [Y_W-1:0]      ld_y1;
  logic [IDX_W-1:0]    pix_idx;
  logic [ADDR_W-1:0]   pix_addr;
  logic                pix_ok;
  logic [DATA_W-1:0]   bit_mask, merged;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata;

  assign in_req  = req_t'(in_ch.req_type);
  assign in_fire = in_ch.valid && in_ready;
  assign ld_x1   = (in_req == REQ_PIXEL) ? in_ch.start_x : in_ch.end_x;
  assign ld_y1   = (in_req == REQ_PIXEL) ? in_ch.start_y : in_ch.end_y;

  fbld_bres u_bres (
    .clk (clk),
    .ctl (bctl),
    .x0  (in_ch.start_x),
    .y0  (in_ch.start_y),
    .x1  (ld_x1),
    .y1  (ld_y1),
    .pos (pos)
  );

  fbld_ram #(
    .DEPTH (FB_BYTES),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    pix_idx  = IDX_W'(pos.x) * IDX_W'(FB_PAGES) + IDX_W'(pos.y >> PAGE_SHIFT);
    pix_addr = pix_idx[ADDR_W-1:0];
    pix_ok   = (int'(pos.x) < DISP_WIDTH) && (int'(pos.y) < DISP_HEIGHT)
            && (int'(pos.y >> PAGE_SHIFT) < FB_PAGES) && (int'(pix_idx) < FB_BYTES);
    bit_mask = DATA_W'(1) << pos.y[PAGE_SHIFT-1:0];
    merged   = on_r ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    sweep_data_nxt = sweep_data_r;
    report_nxt     = report_r;
    req_nxt        = req_r;
    on_nxt         = on_r;
    result_nxt     = result_r;
    in_ready       = 1'b0;
    bctl           = '0;
    ram_we         = 1'b0;
    ram_waddr      = pix_addr;
    ram_wdata      = merged;
    ram_raddr      = pix_addr;
    out_push       = 1'b0;

    unique case (state_r)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = sweep_data_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(FB_BYTES - 1)) begin
          state_nxt = report_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = in_ch.byte_index[ADDR_W-1:0];
        if (in_fire) begin
          req_nxt    = in_req;
          on_nxt     = in_ch.pixel_on;
          result_nxt = '0;
          unique case (in_req)
            REQ_PIXEL, REQ_LINE: begin
              bctl.load = 1'b1;
              state_nxt = ST_PIX_RD;
            end
            REQ_FILL: begin
              cnt_nxt        = '0;
              sweep_data_nxt = in_ch.pixel_on ? '1 : '0;
              report_nxt     = 1'b1;
              state_nxt      = ST_SWEEP;
            end
            REQ_READ: begin
              state_nxt = (int'(in_ch.byte_index) < FB_BYTES) ? ST_BYTE_RD : ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PIX_RD: begin
        if (pix_ok) begin
          state_nxt = ST_PIX_WR;
        end else if (pos.last) begin
          state_nxt = ST_DONE;
        end else begin
          bctl.step = 1'b1;
        end
      end
      ST_PIX_WR: begin
        ram_we = 1'b1;
        if (pos.last) begin
          state_nxt = ST_DONE;
        end else begin
          bctl.step = 1'b1;
          state_nxt = ST_PIX_RD;
        end
      end
      ST_BYTE_RD: begin
        result_nxt = ram_rdata;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    if (out_push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      cnt_r        <= '0;
      sweep_data_r <= '0;
      report_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      sweep_data_r <= sweep_data_nxt;
      report_r     <= report_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    on_r       <= on_nxt;
    result_r   <= result_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;

  a_wr_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PIX_WR) |-> (ram_waddr == $past(ram_raddr)))
    else $error("pixel write address differs from its read address");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("ready stayed high after a request was taken");

  a_push_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result beat raised outside the final cycle");

  a_zero_unless_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && req_r != REQ_READ) |-> (result_r == '0))
    else $error("nonzero result for a request other than a read");

endmodule

// File: dv/tb.sv
// Self-checking testbench for framebuffer_line_drawer_core: pixel, line, fill and read
// requests with random handshake gaps, checked against a local frame buffer mirror.
// Depends on fbld_pkg, fbld_if and the core RTL.
module tb;
  import fbld_pkg::*;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int RANDOM_ITEMS = 578;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    req_t            kind;
    logic [X_W-1:0]  sx;
    logic [Y_W-1:0]  sy;
    logic [X_W-1:0]  ex;
    logic [Y_W-1:0]  ey;
    logic            on;
    logic [BI_W-1:0] bi;
  } fb_req_t;

  logic clk;
  logic rst_n;

  fbld_in_if  in_ch();
  fbld_out_if out_ch();

  framebuffer_line_drawer_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [DATA_W-1:0] fb_mirror [FB_BYTES];
  logic [DATA_W-1:0] pending_bytes [$];
  int                errors_seen;
  int                cycle_count;
  int                stall_left;
  bit                steady;
  int                touched_x;
  int                touched_y;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        $error("read_data: no beat expected, got %0h", out_ch.read_data);
        errors_seen++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.read_data !== want) begin
          $error("read_data: expected %0h, got %0h", want, out_ch.read_data);
          errors_seen++;
        end
      end
    end
  end

  function automatic void fb_plot(int x, int y, bit on);
    int idx;
    if (x < 0 || y < 0 || x >= DISP_WIDTH || y >= DISP_HEIGHT) return;
    idx = x * FB_PAGES + (y >> PAGE_SHIFT);
    fb_mirror[idx][y % 8] = on;
  endfunction

  function automatic void fb_trace_line(int x0, int y0, int x1, int y1, bit on);
    int dx;
    int dy;
    int sx;
    int sy;
    int err;
    int e2;
    int x;
    int y;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    x = x0;
    y = y0;
    forever begin
      fb_plot(x, y, on);
      if (x == x1 && y == y1) break;
      e2 = err * 2;
      if (e2 > -dy) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sy;
      end
    end
  endfunction

  function automatic logic [DATA_W-1:0] fb_predict(fb_req_t r);
    case (r.kind)
      REQ_PIXEL: fb_plot(int'(r.sx), int'(r.sy), r.on);
      REQ_LINE:  fb_trace_line(int'(r.sx), int'(r.sy), int'(r.ex), int'(r.ey), r.on);
      REQ_FILL: begin
        foreach (fb_mirror[i]) fb_mirror[i] = r.on ? 8'hFF : 8'h00;
      end
      REQ_READ: begin
        if (int'(r.bi) < FB_BYTES) return fb_mirror[r.bi];
      end
      default: ;
    endcase
    return '0;
  endfunction

  function automatic fb_req_t random_req(req_t kind);
    fb_req_t r;
    r.kind = kind;
    r.sx   = X_W'($urandom_range(0, DISP_WIDTH - 1));
    r.sy   = Y_W'($urandom_range(0, DISP_HEIGHT - 1));
    r.ex   = X_W'($urandom_range(0, DISP_WIDTH - 1));
    r.ey   = Y_W'($urandom_range(0, DISP_HEIGHT - 1));
    r.on   = 1'($urandom_range(0, 1));
    r.bi   = BI_W'($urandom_range(0, FB_BYTES - 1));
    return r;
  endfunction

  task automatic send_request(fb_req_t r);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    in_ch.req_type   = r.kind;
    in_ch.start_x    = r.sx;
    in_ch.start_y    = r.sy;
    in_ch.end_x      = r.ex;
    in_ch.end_y      = r.ey;
    in_ch.pixel_on   = r.on;
    in_ch.byte_index = r.bi;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_bytes.push_back(fb_predict(r));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_pixel(int x, int y, bit on);
    fb_req_t r;
    r = random_req(REQ_PIXEL);
    r.sx = X_W'(x);
    r.sy = Y_W'(y);
    r.on = on;
    send_request(r);
  endtask

  task automatic send_line(int x0, int y0, int x1, int y1, bit on);
    fb_req_t r;
    r = random_req(REQ_LINE);
    r.sx = X_W'(x0);
    r.sy = Y_W'(y0);
    r.ex = X_W'(x1);
    r.ey = Y_W'(y1);
    r.on = on;
    send_request(r);
  endtask

  task automatic send_fill(bit on);
    fb_req_t r;
    r = random_req(REQ_FILL);
    r.on = on;
    send_request(r);
  endtask

  task automatic send_read(int idx);
    fb_req_t r;
    r = random_req(REQ_READ);
    r.bi = BI_W'(idx);
    send_request(r);
  endtask

  task automatic test_reset_state();
    send_read(0);
    send_read(FB_BYTES - 1);
  endtask

  task automatic test_single_pixels();
    send_pixel(0, 0, 1'b1);
    send_pixel(DISP_WIDTH - 1, DISP_HEIGHT - 1, 1'b1);
    send_read(0);
    send_read(FB_BYTES - 1);
    send_pixel(DISP_WIDTH - 1, DISP_HEIGHT - 1, 1'b0);
    send_read(FB_BYTES - 1);
    send_pixel(5, 37, 1'b1);
    send_read(5 * FB_PAGES + 4);
  endtask

  task automatic test_lines();
    send_line(0, 0, DISP_WIDTH - 1, DISP_HEIGHT - 1, 1'b1);
    send_line(DISP_WIDTH - 1, 0, 0, DISP_HEIGHT - 1, 1'b1);
    send_line(3, 60, 3, 2, 1'b1);
    send_line(120, 10, 7, 10, 1'b1);
    send_line(64, 32, 64, 32, 1'b0);
    send_read(64 * FB_PAGES + 4);
    send_read((DISP_WIDTH - 1) * FB_PAGES);
    send_read(3 * FB_PAGES + 3);
  endtask

  task automatic test_fill();
    send_fill(1'b1);
    send_read(517);
    send_pixel(10, 20, 1'b0);
    send_read(10 * FB_PAGES + 2);
    send_fill(1'b0);
    send_read(10 * FB_PAGES + 2);
  endtask

  task automatic test_random_traffic();
    fb_req_t r;
    int      pick;
    int      d;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = ((n / 80) % 3) == 1;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        r = random_req(REQ_PIXEL);
        touched_x = int'(r.sx);
        touched_y = int'(r.sy);
      end else if (pick < 60) begin
        r = random_req(REQ_LINE);
        if ($urandom_range(0, 9) < 7) begin
          d = $urandom_range(0, 16);
          d = int'(r.sx) + d - 8;
          r.ex = X_W'((d < 0) ? 0 : (d > DISP_WIDTH - 1) ? DISP_WIDTH - 1 : d);
          d = $urandom_range(0, 16);
          d = int'(r.sy) + d - 8;
          r.ey = Y_W'((d < 0) ? 0 : (d > DISP_HEIGHT - 1) ? DISP_HEIGHT - 1 : d);
        end
        touched_x = $urandom_range(0, 1) ? int'(r.sx) : int'(r.ex);
        touched_y = (touched_x == int'(r.sx)) ? int'(r.sy) : int'(r.ey);
      end else if (pick < 96) begin
        r = random_req(REQ_READ);
        if ($urandom_range(0, 1))
          r.bi = BI_W'(touched_x * FB_PAGES + (touched_y >> PAGE_SHIFT));
      end else begin
        r = random_req(REQ_FILL);
      end
      send_request(r);
    end
    steady = 1'b0;
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_PIXEL;
    in_ch.start_x    = '0;
    in_ch.start_y    = '0;
    in_ch.end_x      = '0;
    in_ch.end_y      = '0;
    in_ch.pixel_on   = 1'b0;
    in_ch.byte_index = '0;
    out_ch.ready     = 1'b0;
    errors_seen      = 0;
    cycle_count      = 0;
    stall_left       = 0;
    steady           = 1'b0;
    touched_x        = 0;
    touched_y        = 0;
    foreach (fb_mirror[i]) fb_mirror[i] = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_single_pixels();
    test_lines();
    test_fill();
    test_random_traffic();

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors_seen == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
